### rtl/ptlaf_pkg.sv
// Shared types and codes for the peer table.
package ptlaf_pkg;

    localparam int CW = 7;

    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SWEEP  = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] K_FWD    = 2'd0;
    localparam logic [1:0] K_EVICT  = 2'd1;
    localparam logic [1:0] K_STATUS = 2'd2;

    localparam logic [2:0] ST_KNOWN    = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [23:0] id;
        logic [31:0] last;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_UPD  = 5'b00100,
        S_EMIT = 5'b01000,
        S_STAT = 5'b10000
    } t_state;

endpackage

### rtl/ptlaf_mem.sv
// Peer entry memory, one write port and one registered read port.
module ptlaf_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  ptlaf_pkg::t_entry i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output ptlaf_pkg::t_entry o_rdata
);

    ptlaf_pkg::t_entry r_mem [DEPTH];
    ptlaf_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/peer_table_learn_age_fanout.sv
// Peer table top level: learning, aging sweep and fan-out sequencer.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------
//  item     | in        | start high, busy low    | i_op, i_src_ip, i_src_port, i_src_id
//  result   | out       | o_strobe, one cycle     | o_kind .. o_last
//  config   | in        | i_cfg_valid, o_cfg_ready| i_cfg_data (timeout)
//
// Tick: the status result passes through the S_STAT state and the output register.
// Frame, sweep: two passes over the entry memory's single read port. Remove: one pass.
// The next transaction is accepted at the edge that takes the status result.
// Synchronous active-low reset clears valid flags, time and count, and loads the
// default timeout. Results are one-cycle strobes; the receiver cannot stall them.
module peer_table_learn_age_fanout #(
    parameter int MAX_PEERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_src_port,
    input  logic [23:0] i_src_id,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_peer_ip,
    output logic [15:0] o_peer_port,
    output logic [23:0] o_peer_id,
    output logic [2:0]  o_status,
    output logic [6:0]  o_peer_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_PEERS);
    localparam int CW = ptlaf_pkg::CW;

    ptlaf_pkg::t_state r_state;
    logic [1:0]        r_op;
    logic [31:0]       r_ip;
    logic [15:0]       r_port;
    logic [23:0]       r_id;
    logic [31:0]       r_now;
    logic [15:0]       r_timeout;
    logic [MAX_PEERS-1:0] r_valid;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_nstale;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [23:0]       r_sid;
    logic [2:0]        r_st;
    logic [IW:0]       r_ridx;
    logic              r_rv;
    logic [IW-1:0]     r_didx;

    logic              r_ostb;
    logic [1:0]        r_okind;
    logic [31:0]       r_oip;
    logic [15:0]       r_oport;
    logic [23:0]       r_oid;
    logic [2:0]        r_ost;
    logic              r_olast;

    ptlaf_pkg::t_entry rd;
    ptlaf_pkg::t_entry wdata;
    logic              we;
    logic [IW-1:0]     waddr;
    logic              issue;
    logic              scan_end;
    logic              match;
    logic              vld;
    logic              stale;
    logic              n_ostb;
    logic              free_any;
    logic [IW-1:0]     free_idx;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_PEERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign issue    = ((r_state == ptlaf_pkg::S_SCAN) || (r_state == ptlaf_pkg::S_EMIT))
                      && (r_ridx < (IW+1)'(MAX_PEERS));
    assign scan_end = r_rv && (r_didx == IW'(MAX_PEERS - 1));
    assign match    = (rd.ip == r_ip) && (rd.port == r_port);
    assign vld      = r_valid[r_didx];
    assign stale    = (r_now - rd.last) > {16'd0, r_timeout};
    assign n_ostb   = (r_state == ptlaf_pkg::S_STAT)
                      || ((r_state == ptlaf_pkg::S_EMIT) && r_rv && vld
                          && ((r_op == ptlaf_pkg::OP_SWEEP) ? stale : !match));

    always_comb begin
        we    = (r_state == ptlaf_pkg::S_UPD) && (r_op == ptlaf_pkg::OP_FRAME)
                && (r_hit || free_any);
        waddr = r_hit ? r_hit_idx : free_idx;
        wdata.ip   = r_ip;
        wdata.port = r_port;
        wdata.last = r_now;
        if (r_hit) begin
            wdata.id = ((r_sid == 24'd0) && (r_id != 24'd0)) ? r_id : r_sid;
        end else begin
            wdata.id = r_id;
        end
    end

    ptlaf_mem #(
        .DEPTH (MAX_PEERS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_ridx[IW-1:0]),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ptlaf_pkg::S_IDLE;
            r_now     <= '0;
            r_timeout <= 16'd300;
            r_valid   <= '0;
            r_count   <= '0;
            r_rv      <= 1'b0;
            r_ostb    <= 1'b0;
        end else begin
            r_ostb <= n_ostb;
            r_rv   <= issue;
            r_didx <= r_ridx[IW-1:0];
            if (issue) begin
                r_ridx <= r_ridx + 1'b1;
            end
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            case (r_state)
                ptlaf_pkg::S_IDLE: begin
                    if (start) begin
                        r_op     <= i_op;
                        r_ip     <= i_src_ip;
                        r_port   <= i_src_port;
                        r_id     <= i_src_id;
                        r_hit    <= 1'b0;
                        r_nstale <= '0;
                        r_ridx   <= '0;
                        if (i_op == ptlaf_pkg::OP_TICK) begin
                            r_now   <= r_now + 32'd1;
                            r_st    <= ptlaf_pkg::ST_DONE;
                            r_state <= ptlaf_pkg::S_STAT;
                        end else begin
                            r_state <= ptlaf_pkg::S_SCAN;
                        end
                    end
                end
                ptlaf_pkg::S_SCAN: begin
                    if (r_rv && vld) begin
                        if (r_op == ptlaf_pkg::OP_SWEEP) begin
                            if (stale) begin
                                r_nstale <= r_nstale + 1'b1;
                            end
                        end else if (match && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_didx;
                            r_sid     <= rd.id;
                        end
                    end
                    if (scan_end) begin
                        r_state <= ptlaf_pkg::S_UPD;
                    end
                end
                ptlaf_pkg::S_UPD: begin
                    r_ridx <= '0;
                    case (r_op)
                        ptlaf_pkg::OP_FRAME: begin
                            if (r_hit) begin
                                r_st <= ptlaf_pkg::ST_KNOWN;
                            end else if (free_any) begin
                                r_valid[free_idx] <= 1'b1;
                                r_count <= r_count + 1'b1;
                                r_st    <= ptlaf_pkg::ST_ADDED;
                            end else begin
                                r_st <= ptlaf_pkg::ST_FULL;
                            end
                            r_state <= ptlaf_pkg::S_EMIT;
                        end
                        ptlaf_pkg::OP_SWEEP: begin
                            r_count <= r_count - r_nstale;
                            r_st    <= ptlaf_pkg::ST_DONE;
                            r_state <= ptlaf_pkg::S_EMIT;
                        end
                        default: begin
                            if (r_hit) begin
                                r_valid[r_hit_idx] <= 1'b0;
                                r_count <= r_count - 1'b1;
                                r_st    <= ptlaf_pkg::ST_REMOVED;
                            end else begin
                                r_st <= ptlaf_pkg::ST_NOTFOUND;
                            end
                            r_state <= ptlaf_pkg::S_STAT;
                        end
                    endcase
                end
                ptlaf_pkg::S_EMIT: begin
                    r_oip   <= rd.ip;
                    r_oport <= rd.port;
                    r_oid   <= rd.id;
                    r_ost   <= ptlaf_pkg::ST_KNOWN;
                    r_olast <= 1'b0;
                    if (r_rv && vld) begin
                        if (r_op == ptlaf_pkg::OP_SWEEP) begin
                            if (stale) begin
                                r_valid[r_didx] <= 1'b0;
                                r_okind <= ptlaf_pkg::K_EVICT;
                            end
                        end else if (!match) begin
                            r_okind <= ptlaf_pkg::K_FWD;
                        end
                    end
                    if (scan_end) begin
                        r_state <= ptlaf_pkg::S_STAT;
                    end
                end
                ptlaf_pkg::S_STAT: begin
                    r_okind <= ptlaf_pkg::K_STATUS;
                    r_oip   <= '0;
                    r_oport <= '0;
                    r_oid   <= '0;
                    r_ost   <= r_st;
                    r_olast <= 1'b1;
                    r_state <= ptlaf_pkg::S_IDLE;
                end
                default: begin
                    r_state <= ptlaf_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != ptlaf_pkg::S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_ostb;
    assign o_kind       = r_okind;
    assign o_peer_ip    = r_oip;
    assign o_peer_port  = r_oport;
    assign o_peer_id    = r_oid;
    assign o_status     = r_ost;
    assign o_peer_count = r_count;
    assign o_last       = r_olast;

endmodule

### rtl/ptlaf_chk.sv
// Port-level checker for the peer table, bound to the top level.
module ptlaf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_kind,
    input logic [31:0] o_peer_ip,
    input logic [6:0]  o_peer_count,
    input logic        o_last
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last == (o_kind == ptlaf_pkg::K_STATUS)))
        else $error("last flag disagrees with result kind");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> (o_peer_ip == 32'd0))
        else $error("status result carries an address");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("status result while still busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_peer_count <= 7'd64))
        else $error("peer count out of range");

endmodule

bind peer_table_learn_age_fanout ptlaf_chk u_ptlaf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_kind       (o_kind),
    .o_peer_ip    (o_peer_ip),
    .o_peer_count (o_peer_count),
    .o_last       (o_last)
);
